// File: rtl/sbbl_pkg.sv
// Shared types and codes of the sorted breakpoint blend lookup.
package sbbl_pkg;

	localparam int unsigned MAX_BREAKPOINTS_DEF = 16;

	// Width of the divider operands.
	localparam int unsigned DVD_W = 32;
	localparam int unsigned DVS_W = 16;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	localparam logic [2:0] STATUS_INSERTED = 3'd0;
	localparam logic [2:0] STATUS_REJECTED = 3'd1;
	localparam logic [2:0] STATUS_SINGLE   = 3'd2;
	localparam logic [2:0] STATUS_BLEND    = 3'd3;
	localparam logic [2:0] STATUS_EMPTY    = 3'd4;

	typedef struct packed {
		logic               command;
		logic signed [15:0] value;
		logic [7:0]         sample_id;
		logic [14:0]        time_step;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [7:0]         first_id;
		logic [7:0]         second_id;
		logic [15:0]        blend_factor;
		logic signed [15:0] scaled_step;
	} rsp_t;

endpackage

// File: rtl/sbbl_div.sv
// Restoring unsigned divider that produces one quotient bit per cycle.
module sbbl_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sbbl_pkg::DVD_W-1:0] dividend,
	input  logic [sbbl_pkg::DVS_W-1:0] divisor,
	output logic                       done,
	output logic [sbbl_pkg::DVD_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(sbbl_pkg::DVD_W + 1);

	logic [CNT_W-1:0]           cnt_q;
	logic                       done_q;
	logic [sbbl_pkg::DVS_W-1:0] rem_q;
	logic [sbbl_pkg::DVD_W-1:0] quo_q;
	logic [sbbl_pkg::DVS_W:0]   trial;
	logic [sbbl_pkg::DVS_W:0]   diff;
	logic                       fits;

	always_comb begin
		trial = {rem_q, quo_q[sbbl_pkg::DVD_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(sbbl_pkg::DVD_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// The dividend shifts out of the top of quo_q while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[sbbl_pkg::DVS_W-1:0] : trial[sbbl_pkg::DVS_W-1:0];
			quo_q <= {quo_q[sbbl_pkg::DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/sorted_breakpoint_blend_lookup.sv
// Top level of the sorted breakpoint blend lookup: table memory, sequencer and result register.
// The block holds one item at a time. An insert scans the sorted table one entry per cycle
// up to its place, shifts the entries above it up one slot per cycle and then writes the
// new entry (a rejected insert ends after the scan, an insert into a full table ends
// without a scan). A query reads the last entry, scans up to the lower bound one entry per
// cycle and, when it blends or scales the time step, runs the bit-serial divider. The
// table memory has one read and one write port and needs no clearing after reset. The
// result sits in an output register, so the sequencer takes the next item while a result
// is still stalled.
module sorted_breakpoint_blend_lookup #(
	parameter int unsigned MAX_BREAKPOINTS = sbbl_pkg::MAX_BREAKPOINTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  sbbl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output sbbl_pkg::rsp_t rsp,
	input  logic           cfg_wen,
	input  logic [15:0]    cfg_wdata
);

	localparam int unsigned CNT_W = $clog2(MAX_BREAKPOINTS + 1);
	localparam int unsigned IDX_W = $clog2(MAX_BREAKPOINTS);

	typedef struct packed {
		logic signed [15:0] value;
		logic [7:0]         id;
	} entry_t;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_HI     = 9'b000000010,
		S_SCAN   = 9'b000000100,
		S_EVAL   = 9'b000001000,
		S_SHIFT  = 9'b000010000,
		S_WRITE  = 9'b000100000,
		S_DIVGO  = 9'b001000000,
		S_DIVW   = 9'b010000000,
		S_RESULT = 9'b100000000
	} state_t;

	function automatic logic near(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic [15:0] tol);
		logic [16:0] d;
		logic [16:0] m;
		d = {a[15], a} - {b[15], b};
		m = d[16] ? (~d + 17'd1) : d;
		return m < {1'b0, tol};
	endfunction

	entry_t mem [MAX_BREAKPOINTS];
	entry_t rd_q;
	logic [IDX_W-1:0] rd_addr;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	state_t             state_q;
	sbbl_pkg::req_t     item_q;
	sbbl_pkg::rsp_t     res_q;
	sbbl_pkg::rsp_t     rsp_q;
	logic               rsp_valid_q;
	logic [15:0]        tol_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   k_q;
	logic signed [15:0] lo_q;
	logic signed [15:0] hi_q;
	entry_t             prev_q;
	entry_t             cur_q;
	logic               neg_q;
	logic               blend_mode_q;
	logic [sbbl_pkg::DVD_W-1:0] dvd_q;
	logic [sbbl_pkg::DVS_W-1:0] dvs_q;

	logic [CNT_W-1:0]   cnt_m1;
	logic [CNT_W-1:0]   idx_p1;
	logic [CNT_W-1:0]   k_m1;
	logic [CNT_W-1:0]   k_m2;
	logic               full;
	logic [2:0]         init_status;
	logic               have_prev;
	logic               have_cur;
	logic               near_prev;
	logic               near_cur;
	logic               single_cur;
	logic               single_prev;
	logic               v_lt_lo;
	logic               v_gt_hi;
	logic signed [15:0] cl;
	logic               scale_en;
	logic [16:0]        v_ext;
	logic [16:0]        cl_ext;
	logic [16:0]        v_mag;
	logic [16:0]        cl_mag;
	logic [31:0]        prod;
	logic [16:0]        num;
	logic [16:0]        den;
	logic               out_free;
	logic               div_start;
	logic               div_done;
	logic [sbbl_pkg::DVD_W-1:0] div_quo;
	logic [15:0]        sat_step;

	always_comb begin
		cnt_m1    = count_q - CNT_W'(1);
		idx_p1    = idx_q + CNT_W'(1);
		k_m1      = k_q - CNT_W'(1);
		k_m2      = k_q - CNT_W'(2);
		full      = count_q == CNT_W'(MAX_BREAKPOINTS);
		init_status = (req.command == sbbl_pkg::CMD_INSERT)
			? (full ? sbbl_pkg::STATUS_REJECTED : sbbl_pkg::STATUS_INSERTED)
			: sbbl_pkg::STATUS_EMPTY;
		have_prev = pos_q != '0;
		have_cur  = pos_q != count_q;
		near_prev = have_prev && near(prev_q.value, item_q.value, tol_q);
		near_cur  = have_cur && near(cur_q.value, item_q.value, tol_q);
		// A lower bound of zero always has a current entry, since the table is not empty.
		single_cur  = !have_prev || near_cur;
		single_prev = near_prev || !have_cur;
		v_lt_lo   = item_q.value < lo_q;
		v_gt_hi   = item_q.value > hi_q;
		cl        = v_lt_lo ? lo_q : (v_gt_hi ? hi_q : item_q.value);
		scale_en  = (v_lt_lo || v_gt_hi) && (cl != 16'sd0);
		v_ext     = {item_q.value[15], item_q.value};
		cl_ext    = {cl[15], cl};
		v_mag     = v_ext[16] ? (~v_ext + 17'd1) : v_ext;
		cl_mag    = cl_ext[16] ? (~cl_ext + 17'd1) : cl_ext;
		prod      = 32'(item_q.time_step) * 32'(v_mag[15:0]);
		num       = {item_q.value[15], item_q.value} - {prev_q.value[15], prev_q.value};
		den       = {cur_q.value[15], cur_q.value} - {prev_q.value[15], prev_q.value};
		out_free  = !rsp_valid_q || !rsp_stall;
		div_start = state_q == S_DIVGO;
	end

	// Scaled step: the divider returns a magnitude, the sign comes from value and clamp.
	always_comb begin
		if (neg_q) begin
			sat_step = (div_quo > 32'd32768) ? 16'h8000 : (~div_quo[15:0] + 16'd1);
		end else begin
			sat_step = (div_quo > 32'd32767) ? 16'h7FFF : div_quo[15:0];
		end
	end

	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = (req.command == sbbl_pkg::CMD_QUERY) ? cnt_m1[IDX_W-1:0] : '0;
			S_HI:    rd_addr = '0;
			S_SCAN:  rd_addr = idx_p1[IDX_W-1:0];
			S_EVAL:  rd_addr = cnt_m1[IDX_W-1:0];
			S_SHIFT: rd_addr = k_m2[IDX_W-1:0];
			default: rd_addr = '0;
		endcase
		wr_en   = (state_q == S_SHIFT) || (state_q == S_WRITE);
		wr_addr = (state_q == S_SHIFT) ? k_q[IDX_W-1:0] : pos_q[IDX_W-1:0];
		wr_data = (state_q == S_SHIFT) ? rd_q : entry_t'{item_q.value, item_q.sample_id};
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	sbbl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_q),
		.divisor  (dvs_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			tol_q       <= 16'd1;
			count_q     <= '0;
		end else begin
			if (cfg_wen) begin
				tol_q <= cfg_wdata;
			end
			if (rsp_valid_q && !rsp_stall && state_q != S_RESULT) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						if (req.command == sbbl_pkg::CMD_INSERT) begin
							if (full) begin
								state_q <= S_RESULT;
							end else if (count_q == '0) begin
								state_q <= S_WRITE;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (count_q == '0) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_HI;
						end
					end
				end
				S_HI: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (rd_q.value >= item_q.value || idx_p1 == count_q) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (item_q.command == sbbl_pkg::CMD_INSERT) begin
						if (near_prev || near_cur) begin
							state_q <= S_RESULT;
						end else if (pos_q == count_q) begin
							state_q <= S_WRITE;
						end else begin
							state_q <= S_SHIFT;
						end
					end else if (scale_en || !(single_cur || single_prev)) begin
						state_q <= S_DIVGO;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_SHIFT: begin
					if (k_m1 == pos_q) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= S_RESULT;
				end
				S_DIVGO: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload side of the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				item_q <= req;
				res_q  <= '{status: init_status, first_id: 8'd0, second_id: 8'd0,
					blend_factor: 16'd0, scaled_step: 16'sd0};
				pos_q  <= '0;
				idx_q  <= '0;
			end
			S_HI: begin
				hi_q <= rd_q.value;
			end
			S_SCAN: begin
				if (idx_q == '0) begin
					lo_q <= rd_q.value;
				end
				if (rd_q.value < item_q.value) begin
					prev_q <= rd_q;
					idx_q  <= idx_p1;
					pos_q  <= idx_p1;
				end else begin
					cur_q <= rd_q;
					pos_q <= idx_q;
				end
			end
			S_EVAL: begin
				k_q <= count_q;
				if (item_q.command == sbbl_pkg::CMD_INSERT) begin
					if (near_prev || near_cur) begin
						res_q.status <= sbbl_pkg::STATUS_REJECTED;
					end
				end else begin
					res_q.scaled_step <= {1'b0, item_q.time_step};
					if (single_cur) begin
						res_q.status   <= sbbl_pkg::STATUS_SINGLE;
						res_q.first_id <= cur_q.id;
					end else if (single_prev) begin
						res_q.status   <= sbbl_pkg::STATUS_SINGLE;
						res_q.first_id <= prev_q.id;
					end else begin
						res_q.status    <= sbbl_pkg::STATUS_BLEND;
						res_q.first_id  <= prev_q.id;
						res_q.second_id <= cur_q.id;
					end
					neg_q <= item_q.value[15] ^ cl[15];
					if (scale_en) begin
						blend_mode_q <= 1'b0;
						dvd_q        <= prod;
						dvs_q        <= cl_mag[15:0];
					end else begin
						blend_mode_q <= 1'b1;
						dvd_q        <= {num[15:0], 16'h0000};
						dvs_q        <= den[15:0];
					end
				end
			end
			S_SHIFT: begin
				k_q <= k_m1;
			end
			S_DIVW: begin
				if (div_done) begin
					if (blend_mode_q) begin
						res_q.blend_factor <= div_quo[15:0];
					end else begin
						res_q.scaled_step <= sat_step;
					end
				end
			end
			S_RESULT: begin
				if (out_free) begin
					rsp_q <= res_q;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: rtl/sbbl_chk.sv
// Port-level checker of the sorted breakpoint blend lookup, bound to the top level.
module sbbl_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input sbbl_pkg::rsp_t rsp
);

	// One item at a time: after a request transfer the block holds off the next one.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while an item is in flight");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_single_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != sbbl_pkg::STATUS_BLEND
		|-> rsp.second_id == 8'd0 && rsp.blend_factor == 16'd0)
		else $error("second source reported without a blend");

	a_noquery_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == sbbl_pkg::STATUS_INSERTED
			|| rsp.status == sbbl_pkg::STATUS_REJECTED
			|| rsp.status == sbbl_pkg::STATUS_EMPTY)
		|-> rsp.first_id == 8'd0 && rsp.scaled_step == 16'sd0)
		else $error("insert or empty result carries lookup fields");

endmodule

bind sorted_breakpoint_blend_lookup sbbl_chk u_sbbl_chk (.*);
